### rtl/zyz_pkg.sv
// Shared types, constants and functions of the ZYZ Euler angle unit.
package zyz_pkg;

	localparam int CORDIC_ITER_DEF = 16;
	localparam int CORDIC_ITER_MAX = 24;
	localparam int CW = 28;
	localparam int ZW = 25;
	localparam int SQ_BITS = 24;
	localparam int SQ_NW = 2 * SQ_BITS;

	localparam logic signed [ZW-1:0] ANG_HALF = 25'sd5898240;
	localparam logic signed [ZW-1:0] ANG_QUARTER = 25'sd2949120;
	localparam logic signed [16:0] OUT_LIMIT = 17'sd23040;
	localparam logic [9:0] POLE_MARGIN_RST = 10'd1;

	localparam logic [1:0] POLE_GENERAL = 2'd0;
	localparam logic [1:0] POLE_ZERO = 2'd1;
	localparam logic [1:0] POLE_HALF = 2'd2;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} ent_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 25'sd1474560;
			1: r = 25'sd870484;
			2: r = 25'sd459940;
			3: r = 25'sd233473;
			4: r = 25'sd117189;
			5: r = 25'sd58652;
			6: r = 25'sd29333;
			7: r = 25'sd14667;
			8: r = 25'sd7334;
			9: r = 25'sd3667;
			10: r = 25'sd1833;
			11: r = 25'sd917;
			12: r = 25'sd458;
			13: r = 25'sd229;
			14: r = 25'sd115;
			15: r = 25'sd57;
			16: r = 25'sd29;
			17: r = 25'sd14;
			18: r = 25'sd7;
			19: r = 25'sd4;
			20: r = 25'sd2;
			21: r = 25'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [CW-1:0] scale8(input logic signed [15:0] m);
		return {{(CW-24){m[15]}}, m, 8'b0};
	endfunction

endpackage

### rtl/zyz_cordic.sv
// Pipelined vectoring CORDIC atan2 with output in 1/128 degree.
module zyz_cordic import zyz_pkg::*; #(
	parameter int ITER = CORDIC_ITER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] x,
	input  logic signed [CW-1:0] y,
	output logic                 out_valid,
	output logic signed [15:0]   angle
);

	localparam int NS = (ITER > CORDIC_ITER_MAX) ? CORDIC_ITER_MAX : ITER;

	logic signed [CW-1:0] x_s [0:NS];
	logic signed [CW-1:0] y_s [0:NS];
	logic signed [ZW-1:0] z_s [0:NS];
	logic                 hold_s [0:NS];
	logic                 v_s [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (y == '0) begin
			x_s[0] <= x;
			y_s[0] <= y;
			hold_s[0] <= 1'b1;
			z_s[0] <= x[CW-1] ? ANG_HALF : '0;
		end else if (x == '0) begin
			x_s[0] <= x;
			y_s[0] <= y;
			hold_s[0] <= 1'b1;
			z_s[0] <= y[CW-1] ? -ANG_QUARTER : ANG_QUARTER;
		end else if (x[CW-1]) begin
			x_s[0] <= -x;
			y_s[0] <= -y;
			hold_s[0] <= 1'b0;
			z_s[0] <= y[CW-1] ? -ANG_HALF : ANG_HALF;
		end else begin
			x_s[0] <= x;
			y_s[0] <= y;
			hold_s[0] <= 1'b0;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			hold_s[i+1] <= hold_s[i];
			if (hold_s[i]) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end else if (!y_s[i][CW-1] && y_s[i] != '0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_tab(i);
			end
		end
	end

	logic signed [ZW-1:0] zr;
	logic signed [16:0]   q;
	assign zr = z_s[NS] + ZW'(128);
	assign q = zr[ZW-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (q > OUT_LIMIT) begin
			angle <= OUT_LIMIT[15:0];
		end else if (q < -OUT_LIMIT) begin
			angle <= -OUT_LIMIT[15:0];
		end else begin
			angle <= q[15:0];
		end
	end

endmodule

### rtl/rotation_matrix_to_zyz_euler_unit.sv
// Top level: ZYZ Euler angles from a Q1.14 rotation matrix.
// Usage:
//   Drive the seven entries m00..m22 and raise start for one cycle per beat.
//   busy is always low: a new matrix may enter on every clock cycle.
//   Each result appears on phi, theta, psi and pole_case for exactly one
//   cycle, marked by done, which is registered after the square, sum,
//   square-root and CORDIC stages, in the select stage (above 24
//   iterations counts as 24).
//   Throughput is one matrix per cycle; the path is a square stage, a
//   sum stage, a 24-stage bit-per-stage square root, four parallel CORDIC
//   pipelines (theta, general phi, psi, pole phi) and a select stage.
//   The user writes pole_margin via pole_margin_we / pole_margin_wdata only
//   while no beat is in flight; the block does not enforce it; it resets to 1.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: results must be taken when done is high.
module rotation_matrix_to_zyz_euler_unit import zyz_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               pole_margin_we,
	input  logic [9:0]         pole_margin_wdata,
	input  logic signed [15:0] m00,
	input  logic signed [15:0] m01,
	input  logic signed [15:0] m02,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m20,
	input  logic signed [15:0] m21,
	input  logic signed [15:0] m22,
	output logic               done,
	output logic signed [15:0] phi,
	output logic [14:0]        theta,
	output logic signed [15:0] psi,
	output logic [1:0]         pole_case
);

	logic [9:0] pole_margin_q;
	logic       v_s1;
	ent_t       ent_s1;
	logic [31:0] sq20_s1, sq21_s1;

	logic              sv_s [0:SQ_BITS];
	ent_t              ent_s [0:SQ_BITS];
	logic [SQ_NW-1:0]  rem_s [0:SQ_BITS];
	logic [SQ_BITS-1:0] root_s [0:SQ_BITS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_margin_q <= POLE_MARGIN_RST;
			v_s1 <= 1'b0;
			sv_s[0] <= 1'b0;
		end else begin
			if (pole_margin_we) begin
				pole_margin_q <= pole_margin_wdata;
			end
			v_s1 <= start & ~busy;
			sv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= '{m00: m00, m01: m01, m02: m02, m12: m12, m20: m20, m21: m21, m22: m22};
		sq20_s1 <= 32'(m20) * 32'(m20);
		sq21_s1 <= 32'(m21) * 32'(m21);
		ent_s[0] <= ent_s1;
		rem_s[0] <= {sq20_s1 + sq21_s1, 16'b0};
		root_s[0] <= '0;
	end

	for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
		localparam int B = SQ_BITS - 1 - k;
		logic [SQ_NW-1:0] cand;
		assign cand = ({{(SQ_NW-SQ_BITS){1'b0}}, root_s[k]} << (B + 1))
			+ (SQ_NW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k+1] <= 1'b0;
			end else begin
				sv_s[k+1] <= sv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			ent_s[k+1] <= ent_s[k];
			if (rem_s[k] >= cand) begin
				rem_s[k+1] <= rem_s[k] - cand;
				root_s[k+1] <= root_s[k] | (SQ_BITS'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	ent_t e;
	assign e = ent_s[SQ_BITS];

	logic              vt, vg, vp, vz;
	logic signed [15:0] ang_t, ang_g, ang_p, ang_z;

	zyz_cordic #(.ITER(CORDIC_ITERATIONS)) u_theta (
		.clk(clk), .arst_n(arst_n), .in_valid(sv_s[SQ_BITS]),
		.x(scale8(e.m22)), .y({{(CW-SQ_BITS){1'b0}}, root_s[SQ_BITS]}),
		.out_valid(vt), .angle(ang_t)
	);

	zyz_cordic #(.ITER(CORDIC_ITERATIONS)) u_phi (
		.clk(clk), .arst_n(arst_n), .in_valid(sv_s[SQ_BITS]),
		.x(scale8(e.m20)), .y(scale8(e.m21)),
		.out_valid(vg), .angle(ang_g)
	);

	zyz_cordic #(.ITER(CORDIC_ITERATIONS)) u_psi (
		.clk(clk), .arst_n(arst_n), .in_valid(sv_s[SQ_BITS]),
		.x(-scale8(e.m02)), .y(scale8(e.m12)),
		.out_valid(vp), .angle(ang_p)
	);

	zyz_cordic #(.ITER(CORDIC_ITERATIONS)) u_pole (
		.clk(clk), .arst_n(arst_n), .in_valid(sv_s[SQ_BITS]),
		.x(scale8(e.m00)), .y(scale8(e.m01)),
		.out_valid(vz), .angle(ang_z)
	);

	logic signed [16:0] th_w, pm_w;
	logic near_zero, near_half;
	assign th_w = {ang_t[15], ang_t};
	assign pm_w = {7'b0, pole_margin_q};
	assign near_zero = th_w < pm_w;
	assign near_half = th_w > (OUT_LIMIT - pm_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vt & vg & vp & vz;
		end
	end

	always_ff @(posedge clk) begin
		theta <= ang_t[14:0];
		if (near_zero) begin
			phi <= ang_z;
			psi <= '0;
			pole_case <= POLE_ZERO;
		end else if (near_half) begin
			phi <= -ang_z;
			psi <= '0;
			pole_case <= POLE_HALF;
		end else begin
			phi <= ang_g;
			psi <= ang_p;
			pole_case <= POLE_GENERAL;
		end
	end

endmodule
